// File: sv/encoder_setpoint_decoder_defines.svh
// Assertion macros shared by the encoder setpoint decoder modules.
`ifndef ENCODER_SETPOINT_DECODER_DEFINES_SVH
`define ENCODER_SETPOINT_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/esd_pkg.sv
// Types and constants of the encoder setpoint decoder.
package esd_pkg;

  typedef logic [1:0]  pins_t;
  typedef logic [5:0]  pos_t;
  typedef logic [13:0] mv_t;
  typedef logic [3:0]  digit_t;
  typedef logic [11:0] min_mv_t;
  typedef logic [6:0]  step_mv_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [11:0] cfg_data_t;

  localparam pins_t PINS_DETENT = 2'b00;
  localparam pins_t PINS_CW     = 2'b10;
  localparam pins_t PINS_CCW    = 2'b01;

  localparam cfg_index_t CFG_MIN_MV  = 2'd0;
  localparam cfg_index_t CFG_STEP_MV = 2'd1;
  localparam cfg_index_t CFG_MAX_POS = 2'd2;

  localparam min_mv_t  RESET_MIN_MV  = 12'd225;
  localparam step_mv_t RESET_STEP_MV = 7'd45;
  localparam pos_t     RESET_MAX_POS = 6'd45;

  localparam mv_t SETPOINT_LIMIT = 14'd9999;

  typedef struct packed {
    pos_t   position;
    mv_t    setpoint_mv;
    digit_t digit_ones;
    digit_t digit_tenths;
    digit_t digit_hundredths;
    digit_t digit_thousandths;
  } esd_result_t;

endpackage

// File: sv/esd_stream_if.sv
// Valid/ready channels for pin samples and setpoint results.
interface esd_sample_if import esd_pkg::*;;
  logic valid;
  logic ready;
  logic clk_level;
  logic dt_level;
  modport source(output valid, output clk_level, output dt_level, input ready);
  modport sink(input valid, input clk_level, input dt_level, output ready);
endinterface

interface esd_result_if import esd_pkg::*;;
  logic   valid;
  logic   ready;
  pos_t   position;
  mv_t    setpoint_mv;
  digit_t digit_ones;
  digit_t digit_tenths;
  digit_t digit_hundredths;
  digit_t digit_thousandths;
  modport source(output valid, output position, output setpoint_mv, output digit_ones,
                 output digit_tenths, output digit_hundredths, output digit_thousandths,
                 input ready);
  modport sink(input valid, input position, input setpoint_mv, input digit_ones,
               input digit_tenths, input digit_hundredths, input digit_thousandths,
               output ready);
endinterface

// File: sv/esd_tracker.sv
// Pin state tracking and saturating click position.
`include "encoder_setpoint_decoder_defines.svh"
module esd_tracker import esd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  input  logic clk_level,
  input  logic dt_level,
  output logic up_ready,
  input  pos_t max_position,
  output logic dn_valid,
  output pos_t dn_pos,
  input  logic dn_ready
);

  pins_t      previous_pins;
  pos_t       click_count;
  pins_t      pins;
  logic       accept;
  logic       detent;
  logic [6:0] pos_raw;
  pos_t       pos_next;

  assign pins     = {clk_level, dt_level};
  assign detent   = (pins == PINS_DETENT);
  assign up_ready = !dn_valid || dn_ready;
  assign accept   = up_valid && up_ready;
  assign dn_pos   = click_count;

  always_comb begin
    unique case (previous_pins)
      PINS_CW: begin
        pos_raw = {1'b0, click_count} + 7'd1;
      end
      PINS_CCW: begin
        pos_raw = (click_count == '0) ? 7'd0 : {1'b0, click_count} - 7'd1;
      end
      default: begin
        pos_raw = {1'b0, click_count};
      end
    endcase
    // clamp also pulls down a position left above a lowered maximum
    pos_next = (pos_raw > {1'b0, max_position}) ? max_position : pos_raw[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pins <= PINS_DETENT;
      click_count   <= '0;
      dn_valid      <= 1'b0;
    end else begin
      if (accept) begin
        previous_pins <= pins;
        dn_valid      <= detent;
        if (detent) begin
          click_count <= pos_next;
        end
      end else if (dn_ready) begin
        dn_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_pos_bounded, clk, rst, accept && detent, click_count <= $past(max_position))
  `ASSERT_NEXT(a_pos_held, clk, rst, dn_valid && !dn_ready, $stable(click_count))

endmodule

// File: sv/esd_scale.sv
// Setpoint stage: min plus position times step, saturated.
module esd_scale import esd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  input  pos_t     up_pos,
  output logic     up_ready,
  input  min_mv_t  min_millivolts,
  input  step_mv_t step_millivolts,
  output logic     dn_valid,
  output pos_t     dn_pos,
  output mv_t      dn_mv,
  input  logic     dn_ready
);

  logic [12:0] product;
  mv_t         sum;
  mv_t         mv_sat;
  logic        en;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;
  assign product  = 13'(up_pos) * 13'(step_millivolts);
  assign sum      = {2'b00, min_millivolts} + {1'b0, product};
  assign mv_sat   = (sum > SETPOINT_LIMIT) ? SETPOINT_LIMIT : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      dn_pos <= up_pos;
      dn_mv  <= mv_sat;
    end
  end

endmodule

// File: sv/esd_digits.sv
// Decimal digit split of the setpoint over two stages.
`include "encoder_setpoint_decoder_defines.svh"
module esd_digits import esd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  pos_t        up_pos,
  input  mv_t         up_mv,
  output logic        up_ready,
  output logic        dn_valid,
  output esd_result_t dn_res,
  input  logic        dn_ready
);

  // reciprocals exact for every value up to the setpoint limit
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam logic [13:0] RECIP_1000 = 14'd8389;

  logic        a_en;
  logic        b_en;
  logic        qa_valid;
  pos_t        qa_pos;
  mv_t         qa_mv;
  logic [9:0]  qa_q10;
  logic [6:0]  qa_q100;
  digit_t      qa_q1000;
  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;
  logic [6:0]  rem_tenths;
  logic [9:0]  rem_hundredths;
  logic [13:0] rem_thousandths;
  logic [13:0] recomposed;

  assign b_en     = !dn_valid || dn_ready;
  assign a_en     = !qa_valid || b_en;
  assign up_ready = a_en;

  assign prod10   = 30'(up_mv) * 30'(RECIP_10);
  assign prod100  = 27'(up_mv) * 27'(RECIP_100);
  assign prod1000 = 28'(up_mv) * 28'(RECIP_1000);

  // subtract ten times the next coarser quotient
  assign rem_tenths      = qa_q100 - ({3'b000, qa_q1000} << 3) - ({3'b000, qa_q1000} << 1);
  assign rem_hundredths  = qa_q10 - ({3'b000, qa_q100} << 3) - ({3'b000, qa_q100} << 1);
  assign rem_thousandths = qa_mv - ({4'b0000, qa_q10} << 3) - ({4'b0000, qa_q10} << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      qa_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (a_en) begin
        qa_valid <= up_valid;
      end
      if (b_en) begin
        dn_valid <= qa_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && up_valid) begin
      qa_pos   <= up_pos;
      qa_mv    <= up_mv;
      qa_q10   <= prod10[28:19];
      qa_q100  <= prod100[25:19];
      qa_q1000 <= prod1000[26:23];
    end
    if (b_en && qa_valid) begin
      dn_res.position          <= qa_pos;
      dn_res.setpoint_mv       <= qa_mv;
      dn_res.digit_ones        <= qa_q1000;
      dn_res.digit_tenths      <= rem_tenths[3:0];
      dn_res.digit_hundredths  <= rem_hundredths[3:0];
      dn_res.digit_thousandths <= rem_thousandths[3:0];
    end
  end

  assign recomposed = ({10'd0, dn_res.digit_ones} * 14'd1000)
                    + ({10'd0, dn_res.digit_tenths} * 14'd100)
                    + ({10'd0, dn_res.digit_hundredths} * 14'd10)
                    + {10'd0, dn_res.digit_thousandths};

  `ASSERT_IMPLIES(a_digits_match, clk, rst, dn_valid, recomposed == dn_res.setpoint_mv)
  `ASSERT_IMPLIES(a_low_digit, clk, rst, dn_valid, dn_res.digit_thousandths <= 4'd9)

endmodule

// File: sv/encoder_setpoint_decoder.sv
// Top level of the encoder setpoint decoder.
// Takes one sample of the encoder A/B pins per clock and reports a result at every
// detent (pins at 00): the click position, stepped up after state 10 and down after
// state 01 and held between 0 and max_position, the setpoint min + position * step
// in millivolts (saturated at 9999) and its four decimal digits. A sample is
// accepted every cycle while results drain; the position register with its
// saturating add is the only feedback loop, so throughput is one sample per clock.
// Results pass through a tracker stage, a multiply-add stage and two digit-split
// stages, each of them registered. No clearing pass follows reset.
// Configuration registers: 0 min_millivolts, 1 step_millivolts, 2 max_position;
// other indexes are ignored. Write them only while no result is pending.
module encoder_setpoint_decoder import esd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  esd_sample_if.sink          samples,
  esd_result_if.source        results,
  input  logic                cfg_we,
  input  cfg_index_t          cfg_index,
  input  cfg_data_t           cfg_data
);

  min_mv_t     min_millivolts;
  step_mv_t    step_millivolts;
  pos_t        max_position;
  logic        trk_valid;
  logic        trk_ready;
  pos_t        trk_pos;
  logic        scl_valid;
  logic        scl_ready;
  pos_t        scl_pos;
  mv_t         scl_mv;
  esd_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_millivolts  <= RESET_MIN_MV;
      step_millivolts <= RESET_STEP_MV;
      max_position    <= RESET_MAX_POS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_MV:  min_millivolts  <= cfg_data;
        CFG_STEP_MV: step_millivolts <= cfg_data[6:0];
        CFG_MAX_POS: max_position    <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  esd_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (samples.valid),
    .clk_level    (samples.clk_level),
    .dt_level     (samples.dt_level),
    .up_ready     (samples.ready),
    .max_position (max_position),
    .dn_valid     (trk_valid),
    .dn_pos       (trk_pos),
    .dn_ready     (trk_ready)
  );

  esd_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (trk_valid),
    .up_pos          (trk_pos),
    .up_ready        (trk_ready),
    .min_millivolts  (min_millivolts),
    .step_millivolts (step_millivolts),
    .dn_valid        (scl_valid),
    .dn_pos          (scl_pos),
    .dn_mv           (scl_mv),
    .dn_ready        (scl_ready)
  );

  esd_digits u_digits (
    .clk      (clk),
    .rst      (rst),
    .up_valid (scl_valid),
    .up_pos   (scl_pos),
    .up_mv    (scl_mv),
    .up_ready (scl_ready),
    .dn_valid (results.valid),
    .dn_res   (res),
    .dn_ready (results.ready)
  );

  assign results.position          = res.position;
  assign results.setpoint_mv       = res.setpoint_mv;
  assign results.digit_ones        = res.digit_ones;
  assign results.digit_tenths      = res.digit_tenths;
  assign results.digit_hundredths  = res.digit_hundredths;
  assign results.digit_thousandths = res.digit_thousandths;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the encoder setpoint decoder: pin sample streams checked against a setpoint predictor.
module tb_top;
  import esd_pkg::*;

  localparam cfg_index_t CFG_UNUSED   = 2'd3;
  localparam pins_t      PINS_BOTH    = 2'b11;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 200;

  typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  esd_sample_if smp ();
  esd_result_if res ();

  encoder_setpoint_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (smp),
    .results   (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state and register copies
  pins_t    last_pins;
  pos_t     knob_pos;
  min_mv_t  min_mv;
  step_mv_t step_mv;
  pos_t     max_pos;

  pins_t       pin_samples[$];
  esd_result_t setpoints_due[$];

  int burst_left, gap_left;
  int hold_left, mode_left, hold_requests, hold_served;
  rx_mode_t rx_mode;
  int samples_taken, detents_checked, config_writes, fails, cycle_count;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit next_setpoint(input pins_t pins, output esd_result_t r);
    int pos;
    int mv;
    r = '0;
    if (pins != PINS_DETENT) begin
      last_pins = pins;
      return 1'b0;
    end
    pos = int'(knob_pos);
    // The state seen just before the detent decides the direction.
    if (last_pins == PINS_CW) begin
      pos = pos + 1;
    end else if (last_pins == PINS_CCW && pos > 0) begin
      pos = pos - 1;
    end
    if (pos > int'(max_pos)) pos = int'(max_pos);
    knob_pos  = pos_t'(pos);
    last_pins = pins;
    mv = int'(min_mv) + int'(knob_pos) * int'(step_mv);
    if (mv > int'(SETPOINT_LIMIT)) mv = int'(SETPOINT_LIMIT);
    r.position          = knob_pos;
    r.setpoint_mv       = mv_t'(mv);
    r.digit_ones        = digit_t'((mv / 1000) % 10);
    r.digit_tenths      = digit_t'((mv / 100) % 10);
    r.digit_hundredths  = digit_t'((mv / 10) % 10);
    r.digit_thousandths = digit_t'(mv % 10);
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_MIN_MV:  min_mv = min_mv_t'(data);
      CFG_STEP_MV: step_mv = step_mv_t'(data);
      CFG_MAX_POS: max_pos = pos_t'(data);
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic set_config(input cfg_data_t min_data, input cfg_data_t step_data,
                            input cfg_data_t max_data, input bit poke_unused);
    if (poke_unused) write_reg(CFG_UNUSED, cfg_data_t'($urandom));
    write_reg(CFG_MIN_MV, min_data);
    write_reg(CFG_STEP_MV, step_data);
    write_reg(CFG_MAX_POS, max_data);
    if (poke_unused) write_reg(CFG_UNUSED, cfg_data_t'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Queue a full or partial quadrature cycle that ends at the detent when complete.
  task automatic add_turn(input bit up, input int len);
    pins_t seq[4];
    if (up) seq = '{PINS_CCW, PINS_BOTH, PINS_CW, PINS_DETENT};
    else seq = '{PINS_CW, PINS_BOTH, PINS_CCW, PINS_DETENT};
    for (int k = 0; k < len; k++) pin_samples.push_back(seq[k]);
  endtask

  task automatic add_random(input int count, input int up_pct);
    int r;
    while (pin_samples.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        add_turn($urandom_range(0, 99) < up_pct, 4);
      end else if (r < 90) begin
        pin_samples.push_back(pins_t'($urandom_range(0, 3)));
      end else begin
        add_turn(1'($urandom_range(0, 1)), $urandom_range(1, 3));
      end
    end
  endtask

  task automatic wait_idle();
    while (pin_samples.size() != 0 || smp.valid || setpoints_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic cfg_data_t rand_step_data();
    return cfg_data_t'(($urandom_range(0, 31) << 7) | $urandom_range(0, 95));
  endfunction

  function automatic cfg_data_t rand_max_data(input int hi);
    return cfg_data_t'(($urandom_range(0, 63) << 6) | $urandom_range(0, hi));
  endfunction

  // Sample driver: bursts of items with random gaps in between
  always @(posedge clk) begin
    esd_result_t due;
    pins_t       nxt;
    if (rst) begin
      smp.valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (smp.valid && smp.ready) begin
        samples_taken++;
        if (next_setpoint({smp.clk_level, smp.dt_level}, due)) setpoints_due.push_back(due);
      end
      if (!smp.valid || smp.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          smp.valid <= 1'b0;
        end else if (pin_samples.size() != 0) begin
          nxt = pin_samples.pop_front();
          smp.valid <= 1'b1;
          {smp.clk_level, smp.dt_level} <= nxt;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: rotating stall modes plus long holds on request
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      rx_mode   = RX_FREE;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   res.ready <= 1'b1;
          RX_HALF:   res.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res.ready <= (mode_left % 4 == 0);
          default:   res.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    esd_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (setpoints_due.size() == 0) begin
        $error("result with no setpoint due: position %0d, setpoint_mv %0d",
               res.position, res.setpoint_mv);
        fails++;
      end else begin
        want = setpoints_due.pop_front();
        check_field("position", int'(want.position), int'(res.position));
        check_field("setpoint_mv", int'(want.setpoint_mv), int'(res.setpoint_mv));
        check_field("digit_ones", int'(want.digit_ones), int'(res.digit_ones));
        check_field("digit_tenths", int'(want.digit_tenths), int'(res.digit_tenths));
        check_field("digit_hundredths", int'(want.digit_hundredths),
                    int'(res.digit_hundredths));
        check_field("digit_thousandths", int'(want.digit_thousandths),
                    int'(res.digit_thousandths));
        detents_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d setpoints still due", cycle_count,
               setpoints_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MIN_MV;
    cfg_data      = '0;
    smp.valid     = 1'b0;
    smp.clk_level = 1'b0;
    smp.dt_level  = 1'b0;
    res.ready     = 1'b0;
    last_pins     = PINS_DETENT;
    knob_pos      = '0;
    min_mv        = RESET_MIN_MV;
    step_mv       = RESET_STEP_MV;
    max_pos       = RESET_MAX_POS;
    hold_requests = 0;
    hold_served   = 0;
    samples_taken = 0;
    detents_checked = 0;
    config_writes = 0;
    fails         = 0;
    cycle_count   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: idle detent, down at zero, one click up, detent after 11
    pin_samples.push_back(PINS_DETENT);
    add_turn(1'b0, 4);
    add_turn(1'b1, 4);
    pin_samples.push_back(PINS_BOTH);
    pin_samples.push_back(PINS_DETENT);
    wait_idle();

    // Count up into a low maximum and stay there
    set_config(12'd4000, 12'd95, 12'd2, 1'b0);
    add_turn(1'b1, 4);
    add_turn(1'b1, 4);
    wait_idle();

    // Lower the maximum below the position; upper data bits set, stray index written
    set_config(12'd0, 12'hF80, 12'hFC0, 1'b1);
    pin_samples.push_back(PINS_DETENT);
    add_turn(1'b1, 4);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          set_config(12'd0, 12'd0, 12'd0, 1'b1);
          add_random(100, 50);
        end
        1: begin
          // Beyond the stated ranges: setpoint saturates once the position climbs
          set_config(12'hFFF, 12'h07F, 12'h03F, 1'b0);
          add_random(300, 95);
          hold_requests++;
        end
        2: begin
          set_config(cfg_data_t'($urandom_range(0, 4000)), rand_step_data(),
                     rand_max_data(20), 1'b0);
          add_random(100, 50);
        end
        6: begin
          set_config(12'd4000, 12'd95, 12'd63, 1'b1);
          add_random(200, 90);
        end
        default: begin
          set_config(cfg_data_t'($urandom_range(0, 4000)), rand_step_data(),
                     rand_max_data(63), 1'($urandom_range(0, 1)));
          add_random(100, $urandom_range(10, 90));
          if (p == 4) hold_requests++;
        end
      endcase
      wait_idle();
    end

    $display("Checked %0d detent results from %0d pin samples across %0d register writes",
             detents_checked, samples_taken, config_writes);
    $display("Covered bound saturation, lowered maximum, setpoint overflow and %0d-cycle holds",
             HOLD_CYCLES);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
